// ===== hw/rtl/ambient_light_backlight_ramp_macros.svh =====
// ---------------------------------------------------------------------------
// Ambient light backlight ramp: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef AMBIENT_LIGHT_BACKLIGHT_RAMP_MACROS_SVH
`define AMBIENT_LIGHT_BACKLIGHT_RAMP_MACROS_SVH

// Same-cycle implication
`define ALBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ALBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/albr_pkg.sv =====
// ---------------------------------------------------------------------------
// albr_pkg
// Shared types, constants and the step delay table of the backlight ramp.
// ---------------------------------------------------------------------------
package albr_pkg;

  localparam int NUM_POINTS_DEF = 6;
  localparam int MAX_POINTS     = 6;
  localparam int X_W            = 17;
  localparam int Y_W            = 15;
  localparam int ACC_W          = 33;
  localparam int QUO_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int STEPS_W        = 6;
  localparam int DELAY_W        = 16;

  localparam logic [CFG_IDX_W-1:0] IDX_INIT_LEVEL = 3'd6;
  localparam logic [17:0]          DEADBAND_Q8    = 18'd230;
  localparam logic [8:0]           MAX_STEPS      = 9'd40;

  localparam logic [31:0] POINT_RESET [MAX_POINTS] = '{
    32'd32742, 32'd13135360, 32'd32788480,
    32'd98320640, 32'd327692800, 32'd2147492608
  };

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic search_step;
    logic take_first;
    logic take_zero;
    logic latch_seg;
    logic mul_a;
    logic mul_b;
    logic div_start;
    logic div_step;
    logic eval;
    logic emit_write;
    logic emit_idle;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic found;
    logic first;
    logic at_end;
    logic div_last;
    logic steps_zero;
    logic last_step;
  } stat_t;

  // 300000 / steps, capped at 40000; zero for zero or one step
  function automatic logic [DELAY_W-1:0] step_delay(input logic [STEPS_W-1:0] s);
    logic [DELAY_W-1:0] d;
    case (s) inside
      [6'd2:6'd7]: d = 16'd40000;
      6'd8:  d = 16'd37500;  6'd9:  d = 16'd33333;  6'd10: d = 16'd30000;
      6'd11: d = 16'd27272;  6'd12: d = 16'd25000;  6'd13: d = 16'd23076;
      6'd14: d = 16'd21428;  6'd15: d = 16'd20000;  6'd16: d = 16'd18750;
      6'd17: d = 16'd17647;  6'd18: d = 16'd16666;  6'd19: d = 16'd15789;
      6'd20: d = 16'd15000;  6'd21: d = 16'd14285;  6'd22: d = 16'd13636;
      6'd23: d = 16'd13043;  6'd24: d = 16'd12500;  6'd25: d = 16'd12000;
      6'd26: d = 16'd11538;  6'd27: d = 16'd11111;  6'd28: d = 16'd10714;
      6'd29: d = 16'd10344;  6'd30: d = 16'd10000;  6'd31: d = 16'd9677;
      6'd32: d = 16'd9375;   6'd33: d = 16'd9090;   6'd34: d = 16'd8823;
      6'd35: d = 16'd8571;   6'd36: d = 16'd8333;   6'd37: d = 16'd8108;
      6'd38: d = 16'd7894;   6'd39: d = 16'd7692;   6'd40: d = 16'd7500;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/albr_datapath.sv =====
// ---------------------------------------------------------------------------
// albr_datapath
// Table registers, segment search, interpolation multiply, restoring divider,
// deadband evaluation and the output register.
// ---------------------------------------------------------------------------
module albr_datapath #(
  parameter int NUM_POINTS = albr_pkg::NUM_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [albr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic [15:0]                        light,
  input  albr_pkg::cmd_t                     cmd,
  output albr_pkg::stat_t                    stat,
  output logic [7:0]                         level,
  output logic                               write_valid,
  output logic [albr_pkg::DELAY_W-1:0]       step_delay_us,
  output logic [albr_pkg::STEPS_W-1:0]       total_steps,
  output logic                               last
);

  localparam int IDX_W = $clog2(NUM_POINTS);
  localparam int X_W   = albr_pkg::X_W;
  localparam int Y_W   = albr_pkg::Y_W;

  logic [31:0]      points [NUM_POINTS];
  logic [7:0]       init_level;
  logic [7:0]       cur;
  logic [15:0]      light_r;
  logic [IDX_W-1:0] idx;
  logic [X_W-1:0]   px, seg_a, seg_b, den;
  logic [Y_W-1:0]   py, ycur, target;
  logic [albr_pkg::ACC_W-1:0] acc;
  logic [X_W-1:0]   rem;
  logic [albr_pkg::QUO_W-1:0] quo;
  logic [3:0]       div_cnt;
  logic             dir_up;
  logic [albr_pkg::STEPS_W-1:0] run_steps, remaining;
  logic [albr_pkg::DELAY_W-1:0] run_delay;

  logic [X_W-1:0]   sel_x;
  logic [Y_W-1:0]   sel_y;
  logic [X_W:0]     trial;
  logic             q_bit;
  logic [X_W-1:0]   rem_next;
  logic [albr_pkg::QUO_W-1:0] quo_next;
  logic [7:0]       lvl_base;
  logic signed [17:0] d;
  logic [17:0]      mag;
  logic [8:0]       raw;
  logic             go_up, go_dn;
  logic [albr_pkg::STEPS_W-1:0] cnt;
  logic [7:0]       step_level;

  // table point under search
  assign sel_x = points[idx][31:15];
  assign sel_y = points[idx][14:0];

  assign stat.found      = sel_x >= {1'b0, light_r};
  assign stat.first      = (idx == '0);
  assign stat.at_end     = (idx == IDX_W'(NUM_POINTS - 1));
  assign stat.div_last   = (div_cnt == 4'd15);
  assign stat.steps_zero = (run_steps == '0);
  assign stat.last_step  = (remaining == 6'd1);

  // one restoring divide step
  assign trial    = {rem, quo[albr_pkg::QUO_W-1]} - {1'b0, den};
  assign q_bit    = ~trial[X_W];
  assign rem_next = q_bit ? trial[X_W-1:0] : {rem[X_W-2:0], quo[albr_pkg::QUO_W-1]};
  assign quo_next = {quo[albr_pkg::QUO_W-2:0], q_bit};

  // deadband and step count
  always_comb begin
    lvl_base = (cur == 8'd0) ? init_level : cur;
    d        = $signed({3'b000, target}) - $signed({2'b00, lvl_base, 8'h00});
    mag      = d[17] ? 18'(-d) : 18'(d);
    raw      = mag[16:8];
    go_up    = !d[17] && (d > $signed(albr_pkg::DEADBAND_Q8));
    go_dn    = d[17] && (mag > albr_pkg::DEADBAND_Q8);
    if (!(go_up || go_dn)) begin
      cnt = '0;
    end else if (raw > albr_pkg::MAX_STEPS) begin
      cnt = albr_pkg::MAX_STEPS[albr_pkg::STEPS_W-1:0];
    end else begin
      cnt = raw[albr_pkg::STEPS_W-1:0];
    end
    step_level = dir_up ? cur + 8'd1 : cur - 8'd1;
  end

  // configuration registers and level state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) points[i] <= albr_pkg::POINT_RESET[i];
      init_level <= '0;
      cur        <= '0;
    end else begin
      if (cfg_valid) begin
        for (int i = 0; i < NUM_POINTS; i++) begin
          if (cfg_index == albr_pkg::CFG_IDX_W'(i)) points[i] <= cfg_data;
        end
        if (cfg_index == albr_pkg::IDX_INIT_LEVEL) init_level <= cfg_data[7:0];
      end
      if (cmd.eval) cur <= lvl_base;
      if (cmd.emit_write) cur <= step_level;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      light_r <= light;
      idx     <= '0;
    end
    if (cmd.search_step) begin
      idx <= idx + 1'b1;
      px  <= sel_x;
      py  <= sel_y;
    end
    if (cmd.take_first) target <= sel_y;
    if (cmd.take_zero) target <= '0;
    if (cmd.latch_seg) begin
      seg_a <= {1'b0, light_r} - px;
      seg_b <= sel_x - {1'b0, light_r};
      den   <= sel_x - px;
      ycur  <= sel_y;
    end
    // products fit in 32 bits, their sum in 33
    if (cmd.mul_a) acc <= albr_pkg::ACC_W'(32'(seg_a) * 32'(ycur));
    if (cmd.mul_b) acc <= acc + albr_pkg::ACC_W'(32'(seg_b) * 32'(py));
    if (cmd.div_start) begin
      rem     <= acc[albr_pkg::ACC_W-1:albr_pkg::QUO_W];
      quo     <= acc[albr_pkg::QUO_W-1:0];
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= rem_next;
      quo     <= quo_next;
      div_cnt <= div_cnt + 4'd1;
      if (stat.div_last) target <= quo_next[Y_W-1:0];
    end
    if (cmd.eval) begin
      dir_up    <= go_up;
      run_steps <= cnt;
      remaining <= cnt;
      run_delay <= albr_pkg::step_delay(cnt);
    end
    if (cmd.emit_write) remaining <= remaining - 6'd1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit_write) begin
      level         <= step_level;
      write_valid   <= 1'b1;
      step_delay_us <= run_delay;
      total_steps   <= run_steps;
      last          <= stat.last_step;
    end else if (cmd.emit_idle) begin
      level         <= cur;
      write_valid   <= 1'b0;
      step_delay_us <= '0;
      total_steps   <= '0;
      last          <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/albr_ctrl.sv =====
// ---------------------------------------------------------------------------
// albr_ctrl
// Sequencer: search, multiply, divide, evaluate, then emit the results.
// ---------------------------------------------------------------------------
module albr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  albr_pkg::stat_t stat,
  output albr_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_MUL_A, S_MUL_B, S_DIV_LOAD, S_DIV, S_EVAL, S_EMIT
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_SEARCH: begin
        if (stat.found && stat.first) cmd.take_first = 1'b1;
        else if (stat.found) cmd.latch_seg = 1'b1;
        else if (stat.at_end) cmd.take_zero = 1'b1;
        else cmd.search_step = 1'b1;
      end
      S_MUL_A: cmd.mul_a = 1'b1;
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
      end
      S_DIV_LOAD: cmd.div_start = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_EVAL: cmd.eval = 1'b1;
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_idle  = stat.steps_zero;
          cmd.emit_write = !stat.steps_zero;
        end
      end
      default: ;
    endcase
  end

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat.found && !stat.first) state <= S_MUL_A;
          else if (stat.found || stat.at_end) state <= S_EVAL;
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_DIV_LOAD;
        S_DIV_LOAD: state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) state <= S_EVAL;
        end
        S_EVAL: state <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            if (stat.steps_zero || stat.last_step) begin
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ambient_light_backlight_ramp.sv =====
// ---------------------------------------------------------------------------
// ambient_light_backlight_ramp
// Light reading to backlight level through a six point table and a step ramp.
// ---------------------------------------------------------------------------
// One reading is handled at a time. After the accepting cycle the table search
// steps through the points one at a time; an interpolated segment then passes
// through S_MUL_A, S_MUL_B, the divider load state and the restoring divide,
// and every reading then takes the evaluate state. Each result then leaves one
// per cycle while out_ready is high, and the input reopens the cycle after the
// last result is issued; output stalls hold the results back. Configuration
// writes are always taken (cfg_ready is tied high) and belong only between
// readings, with no result outstanding; index 6 is initial_level.
`include "ambient_light_backlight_ramp_macros.svh"

module ambient_light_backlight_ramp #(
  parameter int NUM_POINTS = albr_pkg::NUM_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    light,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     level,
  output logic                           write_valid,
  output logic [albr_pkg::DELAY_W-1:0]   step_delay_us,
  output logic [albr_pkg::STEPS_W-1:0]   total_steps,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [albr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  albr_pkg::cmd_t  cmd;
  albr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  albr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  albr_datapath #(.NUM_POINTS(NUM_POINTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .light         (light),
    .cmd           (cmd),
    .stat          (stat),
    .level         (level),
    .write_valid   (write_valid),
    .step_delay_us (step_delay_us),
    .total_steps   (total_steps),
    .last          (last)
  );

  // busy after a transaction is taken
  `ALBR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  // a write result carries a step count in range
  `ALBR_ASSERT_IMP(a_write_steps, out_valid && write_valid,
                   total_steps != 6'd0 && total_steps <= 6'd40, "bad step count")
  // a no-change result is alone and carries no run
  `ALBR_ASSERT_IMP(a_idle_result, out_valid && !write_valid,
                   last && total_steps == 6'd0 && step_delay_us == 16'd0, "bad idle result")
  // more results pending keeps the input closed
  `ALBR_ASSERT_IMP(a_run_open, out_valid && !last, !in_ready, "input opened mid run")

endmodule

// ===== sim/ambient_light_backlight_ramp_checker.sv =====
// ---------------------------------------------------------------------------
// Ambient light backlight ramp checker
// Watches the configuration, input and result channels, predicts the step
// writes or no-change result of every accepted reading and compares each accepted result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ambient_light_backlight_ramp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] light,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  level,
  input  logic        write_valid,
  input  logic [15:0] step_delay_us,
  input  logic [5:0]  total_steps,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          write_count,
  output int          hold_count
);

  typedef struct packed {
    logic [7:0]  level;
    logic        write_valid;
    logic [15:0] step_delay_us;
    logic [5:0]  total_steps;
    logic        last;
  } ramp_result_t;

  logic [31:0]  point_tbl [albr_pkg::MAX_POINTS];
  logic [7:0]   init_lvl;
  logic [7:0]   cur_lvl;
  ramp_result_t ramp_q [$];

  assign pending = ramp_q.size();

  // Table lookup with linear interpolation between neighbors
  function automatic longint light_target(input logic [15:0] lt);
    longint px, py, x, y;
    px = 0;
    py = 0;
    for (int i = 0; i < albr_pkg::NUM_POINTS_DEF; i++) begin
      x = point_tbl[i][31:15];
      y = point_tbl[i][14:0];
      if (x >= lt) begin
        if (i == 0) return y;
        return ((lt - px) * y + (x - lt) * py) / (x - px);
      end
      px = x;
      py = y;
    end
    return 0;
  endfunction

  // Build the expected write run for one reading
  task automatic predict_ramp(input logic [15:0] lt);
    longint tgt, d;
    int steps, dly;
    bit up;
    ramp_result_t r;
    tgt = light_target(lt);
    if (cur_lvl == 0) cur_lvl = init_lvl;
    d = tgt - longint'(cur_lvl) * 256;
    steps = 0;
    up = (d > 0);
    if (d > 230) steps = d / 256;
    else if (d < -230) steps = (-d) / 256;
    if (steps > 40) steps = 40;
    dly = 0;
    if (steps > 1) begin
      dly = 300000 / steps;
      if (dly > 40000) dly = 40000;
    end
    if (steps == 0) begin
      r = '{level: cur_lvl, write_valid: 1'b0, step_delay_us: '0, total_steps: '0,
            last: 1'b1};
      ramp_q.push_back(r);
    end else begin
      for (int k = 0; k < steps; k++) begin
        cur_lvl = up ? cur_lvl + 8'd1 : cur_lvl - 8'd1;
        r = '{level: cur_lvl, write_valid: 1'b1, step_delay_us: 16'(dly),
              total_steps: 6'(steps), last: (k == steps - 1)};
        ramp_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    ramp_result_t exp_r;
    if (rst) begin
      foreach (point_tbl[i]) point_tbl[i] <= albr_pkg::POINT_RESET[i];
      init_lvl <= '0;
      cur_lvl = '0;
      ramp_q.delete();
      fail_count <= 0;
      write_count <= 0;
      hold_count <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < albr_pkg::IDX_INIT_LEVEL) point_tbl[cfg_index] <= cfg_data;
        else if (cfg_index == albr_pkg::IDX_INIT_LEVEL) init_lvl <= cfg_data[7:0];
      end
      // compare result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (ramp_q.size() == 0) begin
          $display("%0t: unexpected result level=%0d write=%0b", $time, level, write_valid);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = ramp_q.pop_front();
          if (exp_r != {level, write_valid, step_delay_us, total_steps, last}) begin
            $display("%0t: mismatch expected lvl=%0d wr=%0b dly=%0d st=%0d last=%0b",
                     $time, exp_r.level, exp_r.write_valid, exp_r.step_delay_us,
                     exp_r.total_steps, exp_r.last);
            $display("%0t:          actual   lvl=%0d wr=%0b dly=%0d st=%0d last=%0b",
                     $time, level, write_valid, step_delay_us, total_steps, last);
            fail_count <= fail_count + 1;
          end
          if (write_valid) write_count <= write_count + 1;
          else hold_count <= hold_count + 1;
        end
      end
      // reading transaction
      if (in_valid && in_ready) predict_ramp(light);
    end
  end

endmodule

// ===== sim/ambient_light_backlight_ramp_test.sv =====
// ---------------------------------------------------------------------------
// Ambient light backlight ramp testbench
// Drives readings through several table and start-level settings with random
// idling on both sides; a checker predicts every result and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ambient_light_backlight_ramp_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] light;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  level;
  logic        write_valid;
  logic [15:0] step_delay_us;
  logic [5:0]  total_steps;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          write_count;
  int          hold_count;
  int          idle_cycles;
  int          readings_sent;
  bit          calm_phase;
  bit          long_hold;

  ambient_light_backlight_ramp u_top (.*);

  ambient_light_backlight_ramp_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ambient_light_backlight_ramp regression: fail");
      $finish;
    end
  end

  // One register write; valid drops for a cycle before the next one
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One reading; the block is busy in the cycle after acceptance anyway
  task automatic send_reading(input logic [15:0] lt);
    int n;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    light    <= lt;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    readings_sent++;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Sorted random table: x spread across the reading range, y below 128.0
  task automatic load_table(input bit extreme);
    logic [16:0] x;
    logic [14:0] y;
    x = 0;
    for (int i = 0; i < albr_pkg::MAX_POINTS; i++) begin
      x = (i == albr_pkg::MAX_POINTS - 1 && extreme) ? 17'h1ffff :
          17'(x + $urandom_range(1, 14000));
      y = extreme ? ((i % 2) ? 15'h7fff : 15'd0) : 15'($urandom_range(0, 32767));
      write_reg(3'(i), {x, y});
    end
  endtask

  initial begin
    logic [15:0] dir_light [] = '{16'd0, 16'hffff, 16'd1, 16'd0, 16'd199, 16'd200,
                                  16'd401, 16'd1000, 16'd3000, 16'd9999, 16'd10000,
                                  16'd65535, 16'h5555, 16'haaaa, 16'd0};
    rst = 1'b1;
    in_valid = 1'b0;
    light = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm_phase = 1'b0;
    long_hold = 1'b0;
    readings_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset table, then start level extremes
    foreach (dir_light[i]) send_reading(dir_light[i]);
    drain();
    write_reg(albr_pkg::IDX_INIT_LEVEL, 32'hffffffff);
    load_table(1'b1);
    send_reading(16'd0);
    send_reading(16'hffff);
    send_reading(16'h8000);
    send_reading(16'd1);
    drain();
    write_reg(albr_pkg::IDX_INIT_LEVEL, 32'd1);
    write_reg(3'd5, 32'hffffffff);

    // Random phases with varied tables and start levels
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 5) calm_phase = 1'b1;
      write_reg(albr_pkg::IDX_INIT_LEVEL, 32'($urandom_range(0, 255)));
      if (ph == 3) begin
        for (int i = 0; i < albr_pkg::MAX_POINTS; i++) write_reg(3'(i), $urandom());
      end else begin
        load_table(ph == 4);
      end
      if (ph == 2) long_hold = 1'b1;
      for (int k = 0; k < 27; k++)
        send_reading($urandom_range(0, 3) == 0 ? 16'($urandom()) :
                     16'($urandom_range(0, 70000 / 2)));
    end

    drain();
    $display("readings sent: %0d, step writes checked: %0d, no-change results: %0d",
             readings_sent, write_count, hold_count);
    $display("table extremes, unsorted tables and start levels 0..255 were covered");
    if (fail_count == 0) begin
      $display("ambient_light_backlight_ramp regression: pass");
    end else begin
      $display("ambient_light_backlight_ramp regression: fail");
    end
    $finish;
  end

endmodule
